FILE: rtl/amkc_pkg.sv
// Package: shared constants, types and helper functions for the keystream cipher.
`timescale 1ns / 1ps
`default_nettype none

package amkc_pkg;

    // Round count default and key store geometry
    localparam int ROUNDS_DEF  = 16;
    localparam int KEY_DEPTH   = 64;
    localparam int KEY_BANKS   = 4;
    localparam int KEY_ROWS    = KEY_DEPTH / KEY_BANKS;
    localparam int KEY_ROW_W   = $clog2(KEY_ROWS);
    localparam int KEY_IDX_W   = $clog2(KEY_DEPTH);
    localparam int BANK_W      = $clog2(KEY_BANKS);

    // Field widths
    localparam int WORD_W      = 32;
    localparam int HALF_W      = 64;
    localparam int BLOCK_W     = 128;
    localparam int BLOCK_BYTES = 16;
    localparam int COUNT_W     = 5;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;

    // Stream bus widths (zero padded to whole bytes)
    localparam int S_TDATA_W   = 208;
    localparam int M_TDATA_W   = 168;

    // Beat kinds carried in tuser
    localparam logic [KIND_W-1:0] KIND_KEY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DATA  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE2 = 2'd2;

    // Round multipliers and mix rotations
    localparam logic [WORD_W-1:0] MUL0 = 32'h71e961dd;
    localparam logic [WORD_W-1:0] MUL1 = 32'h47dff15d;
    localparam logic [WORD_W-1:0] MUL2 = 32'h172f4f2f;
    localparam logic [WORD_W-1:0] MUL3 = 32'hf9c1e3c7;
    localparam int ROT0 = 13;
    localparam int ROT1 = 7;
    localparam int ROT2 = 11;
    localparam int ROT3 = 15;

    // Datapath commands from the controller
    typedef struct packed {
        logic key_we;    // write one round key word
        logic ctr_set;   // load block counter
        logic start;     // seed state words, capture data block
        logic mix0;      // first half of rotate-add mix
        logic mix1;      // second half of rotate-add mix
        logic mul;       // multiply and key xor
        logic out_load;  // fill output register
    } t_dp_cmd;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    // Byte mask over a 128-bit block, lowest cnt bytes set
    function automatic logic [BLOCK_W-1:0] byte_mask(input logic [COUNT_W-1:0] cnt);
        logic [BLOCK_W-1:0] m;
        m = '0;
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            m[8*i +: 8] = (COUNT_W'(i) < cnt) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/arx_mul_ctr_keystream_cipher.sv
// Top level: counter-mode keystream cipher, stream ports and configuration port.
//
// Input stream: tuser carries the beat kind. A key beat writes one round key
// word, a start beat loads the block counter; both give no output and leave
// the input ready. A data beat with a nonzero byte count is encrypted with
// the current counter, which then advances by one (mod 2^32); a zero count
// is dropped. Each data block runs ROUNDS rounds, each of two mix steps and
// one multiply/key step, reading four key banks once per round. The result is
// loaded into the output register once the last round is done and the
// register is free; the input takes no new beat until then.
// The output register holds a finished block while the next one computes; if
// the receiver stalls, the next block waits in the core until the register
// frees, and the input stays not ready until then.
// Reset (synchronous, active low) clears the nonces, the block counter and
// the output valid. Round keys are not cleared and must be loaded before use.
// Nonce registers are written through the configuration port; the user must
// do so only while idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module arx_mul_ctr_keystream_cipher #(
    parameter int ROUNDS = amkc_pkg::ROUNDS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [amkc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [amkc_pkg::WORD_W-1:0]         i_cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // key_index, key_word, counter_start, data_low, data_high, byte_count
    input  wire logic [amkc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // kind
    input  wire logic [amkc_pkg::KIND_W-1:0]         s_axis_tuser,
    // output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // result_low, result_high, result_bytes, counter_used
    output logic      [amkc_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    amkc_pkg::t_dp_cmd                   w_cmd;
    logic [amkc_pkg::KEY_ROW_W-1:0]      w_key_row;
    logic [amkc_pkg::HALF_W-1:0]         w_result_low, w_result_high;
    logic [amkc_pkg::COUNT_W-1:0]        w_result_bytes;
    logic [amkc_pkg::WORD_W-1:0]         w_counter_used;

    // Input beat fields
    logic [amkc_pkg::KEY_IDX_W-1:0]      w_key_index;
    logic [amkc_pkg::WORD_W-1:0]         w_key_word;
    logic [amkc_pkg::WORD_W-1:0]         w_counter_start;
    logic [amkc_pkg::HALF_W-1:0]         w_data_low, w_data_high;
    logic [amkc_pkg::COUNT_W-1:0]        w_byte_count;

    assign w_key_index     = s_axis_tdata[5:0];
    assign w_key_word      = s_axis_tdata[37:6];
    assign w_counter_start = s_axis_tdata[69:38];
    assign w_data_low      = s_axis_tdata[133:70];
    assign w_data_high     = s_axis_tdata[197:134];
    assign w_byte_count    = s_axis_tdata[202:198];

    amkc_ctl #(
        .ROUNDS (ROUNDS)
    ) u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_kind       (s_axis_tuser),
        .i_byte_count (w_byte_count),
        .o_s_ready    (s_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_cmd        (w_cmd),
        .o_key_row    (w_key_row)
    );

    amkc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_key_row       (w_key_row),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_key_index     (w_key_index),
        .i_key_word      (w_key_word),
        .i_counter_start (w_counter_start),
        .i_data_low      (w_data_low),
        .i_data_high     (w_data_high),
        .i_byte_count    (w_byte_count),
        .o_result_low    (w_result_low),
        .o_result_high   (w_result_high),
        .o_result_bytes  (w_result_bytes),
        .o_counter_used  (w_counter_used)
    );

    // Output beat packing, padded to whole bytes
    assign m_axis_tdata = {3'b000, w_counter_used, w_result_bytes,
                           w_result_high, w_result_low};

endmodule

`default_nettype wire

FILE: rtl/amkc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module amkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/amkc_ctl.sv
// Controller: beat decode, round sequencing and output valid.
`timescale 1ns / 1ps
`default_nettype none

module amkc_ctl #(
    parameter int ROUNDS = amkc_pkg::ROUNDS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_valid,
    input  wire logic [amkc_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [amkc_pkg::COUNT_W-1:0]      i_byte_count,
    output logic                                   o_s_ready,
    output logic                                   o_m_valid,
    input  wire logic                              i_m_ready,
    output amkc_pkg::t_dp_cmd                      o_cmd,
    output logic      [amkc_pkg::KEY_ROW_W-1:0]    o_key_row
);

    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX0,
        S_MIX1,
        S_MUL,
        S_HOLD
    } t_state;

    t_state          r_state;
    logic   [RW-1:0] r_round;
    logic            r_m_valid;

    logic                                w_accept;
    logic                                w_last_round;
    logic [RW+amkc_pkg::KEY_ROW_W-1:0]   w_round_ext;

    assign w_accept     = i_s_valid && (r_state == S_IDLE);
    assign w_last_round = (r_round == RW'(ROUNDS - 1));

    // Command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.key_we   = w_accept && (i_kind == amkc_pkg::KIND_KEY);
        o_cmd.ctr_set  = w_accept && (i_kind == amkc_pkg::KIND_START);
        o_cmd.start    = w_accept && (i_kind == amkc_pkg::KIND_DATA)
                         && (i_byte_count != '0);
        o_cmd.mix0     = (r_state == S_MIX0);
        o_cmd.mix1     = (r_state == S_MIX1);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.out_load = (r_state == S_HOLD) && (!r_m_valid || i_m_ready);
    end

    // Key row for the current round wraps over the key store
    assign w_round_ext = {{amkc_pkg::KEY_ROW_W{1'b0}}, r_round};
    assign o_key_row   = w_round_ext[amkc_pkg::KEY_ROW_W-1:0];

    // State, round counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_round   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (o_cmd.start) begin
                        r_round <= '0;
                        r_state <= S_MIX0;
                    end
                end
                S_MIX0: begin
                    r_state <= S_MIX1;
                end
                S_MIX1: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (w_last_round) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_round <= r_round + RW'(1);
                        r_state <= S_MIX0;
                    end
                end
                S_HOLD: begin
                    if (o_cmd.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

endmodule

`default_nettype wire

FILE: rtl/amkc_dp.sv
// Datapath: nonce registers, block counter, key banks, round state words, output register.
`timescale 1ns / 1ps
`default_nettype none

module amkc_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire amkc_pkg::t_dp_cmd                   i_cmd,
    input  wire logic [amkc_pkg::KEY_ROW_W-1:0]      i_key_row,
    input  wire logic                                i_cfg_we,
    input  wire logic [amkc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [amkc_pkg::WORD_W-1:0]         i_cfg_data,
    input  wire logic [amkc_pkg::KEY_IDX_W-1:0]      i_key_index,
    input  wire logic [amkc_pkg::WORD_W-1:0]         i_key_word,
    input  wire logic [amkc_pkg::WORD_W-1:0]         i_counter_start,
    input  wire logic [amkc_pkg::HALF_W-1:0]         i_data_low,
    input  wire logic [amkc_pkg::HALF_W-1:0]         i_data_high,
    input  wire logic [amkc_pkg::COUNT_W-1:0]        i_byte_count,
    output logic      [amkc_pkg::HALF_W-1:0]         o_result_low,
    output logic      [amkc_pkg::HALF_W-1:0]         o_result_high,
    output logic      [amkc_pkg::COUNT_W-1:0]        o_result_bytes,
    output logic      [amkc_pkg::WORD_W-1:0]         o_counter_used
);

    localparam int W = amkc_pkg::WORD_W;

    // Configuration and counter
    logic [W-1:0] r_nonce0, r_nonce1, r_nonce2;
    logic [W-1:0] r_ctr;

    // Working block
    logic [W-1:0]                     r_v0, r_v1, r_v2, r_v3;
    logic [amkc_pkg::BLOCK_W-1:0]     r_data;
    logic [amkc_pkg::COUNT_W-1:0]     r_count;
    logic [W-1:0]                     r_ctr_used;

    // Output register
    logic [amkc_pkg::BLOCK_W-1:0]     r_res;
    logic [amkc_pkg::COUNT_W-1:0]     r_res_bytes;
    logic [W-1:0]                     r_res_ctr;

    logic [W-1:0]                     w_key [amkc_pkg::KEY_BANKS];
    logic [amkc_pkg::COUNT_W-1:0]     w_count_sat;
    logic [W-1:0]                     w_mix0_v0, w_mix0_v1, w_mix1_v2, w_mix1_v3;
    logic [W-1:0]                     w_mul_v0, w_mul_v1, w_mul_v2, w_mul_v3;

    // One key bank per word of a round; row selects the round
    for (genvar j = 0; j < amkc_pkg::KEY_BANKS; j++) begin : g_bank
        amkc_ram #(
            .WIDTH (W),
            .DEPTH (amkc_pkg::KEY_ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (i_cmd.key_we
                      && (i_key_index[amkc_pkg::BANK_W-1:0] == amkc_pkg::BANK_W'(j))),
            .i_waddr (i_key_index[amkc_pkg::KEY_IDX_W-1:amkc_pkg::BANK_W]),
            .i_wdata (i_key_word),
            .i_raddr (i_key_row),
            .o_rdata (w_key[j])
        );
    end

    // Byte count above a full block saturates
    assign w_count_sat = (i_byte_count > amkc_pkg::COUNT_W'(amkc_pkg::BLOCK_BYTES))
                         ? amkc_pkg::COUNT_W'(amkc_pkg::BLOCK_BYTES) : i_byte_count;

    // Mix, first half: v0 and v1 as flat multi-operand sums (u = v2 + v3)
    assign w_mix0_v0 = amkc_pkg::rotl32(r_v0, amkc_pkg::ROT0) + r_v1 + r_v2 + r_v3;
    assign w_mix0_v1 = amkc_pkg::rotl32(r_v1, amkc_pkg::ROT1)
                       + amkc_pkg::rotl32(r_v0, amkc_pkg::ROT0) + r_v1
                       + (r_v2 << 1) + (r_v3 << 1);

    // Mix, second half: v2 and v3 from new v0, v1 (p = v0 + v1) and old v2, v3
    assign w_mix1_v2 = amkc_pkg::rotl32(r_v2, amkc_pkg::ROT2) + r_v3 + r_v0 + r_v1;
    assign w_mix1_v3 = amkc_pkg::rotl32(r_v3, amkc_pkg::ROT3)
                       + amkc_pkg::rotl32(r_v2, amkc_pkg::ROT2) + r_v3
                       + (r_v0 << 1) + (r_v1 << 1);

    // Multiply by round constants mod 2^32, then round key xor
    assign w_mul_v0 = (r_v0 * amkc_pkg::MUL0) ^ w_key[0];
    assign w_mul_v1 = (r_v1 * amkc_pkg::MUL1) ^ w_key[1];
    assign w_mul_v2 = (r_v2 * amkc_pkg::MUL2) ^ w_key[2];
    assign w_mul_v3 = (r_v3 * amkc_pkg::MUL3) ^ w_key[3];

    // Nonce registers and block counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonce0 <= '0;
            r_nonce1 <= '0;
            r_nonce2 <= '0;
            r_ctr    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    amkc_pkg::CFG_NONCE0: r_nonce0 <= i_cfg_data;
                    amkc_pkg::CFG_NONCE1: r_nonce1 <= i_cfg_data;
                    amkc_pkg::CFG_NONCE2: r_nonce2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.ctr_set) begin
                r_ctr <= i_counter_start;
            end else if (i_cmd.start) begin
                r_ctr <= r_ctr + W'(1);
            end
        end
    end

    // Round state words and captured block
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_v0       <= r_nonce0;
            r_v1       <= r_nonce1;
            r_v2       <= r_nonce2;
            r_v3       <= r_ctr;
            r_ctr_used <= r_ctr;
            r_data     <= {i_data_high, i_data_low};
            r_count    <= w_count_sat;
        end else if (i_cmd.mix0) begin
            r_v0 <= w_mix0_v0;
            r_v1 <= w_mix0_v1;
        end else if (i_cmd.mix1) begin
            r_v2 <= w_mix1_v2;
            r_v3 <= w_mix1_v3;
        end else if (i_cmd.mul) begin
            r_v0 <= w_mul_v0;
            r_v1 <= w_mul_v1;
            r_v2 <= w_mul_v2;
            r_v3 <= w_mul_v3;
        end
    end

    // Output register: data xor keystream, bytes past the count zeroed
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res       <= (r_data ^ {r_v3, r_v2, r_v1, r_v0})
                           & amkc_pkg::byte_mask(r_count);
            r_res_bytes <= r_count;
            r_res_ctr   <= r_ctr_used;
        end
    end

    assign o_result_low   = r_res[amkc_pkg::HALF_W-1:0];
    assign o_result_high  = r_res[amkc_pkg::BLOCK_W-1:amkc_pkg::HALF_W];
    assign o_result_bytes = r_res_bytes;
    assign o_counter_used = r_res_ctr;

endmodule

`default_nettype wire

FILE: bench/tb_arx_mul_ctr_keystream_cipher.sv
// Testbench for the counter-mode keystream cipher: directed and random beats checked against a local predictor.
`timescale 1ns / 1ps

module tb_arx_mul_ctr_keystream_cipher;
    import amkc_pkg::*;

    localparam int ROUND_COUNT = ROUNDS_DEF;
    localparam int SETTLE_CYCLES = 3 * ROUND_COUNT + 12;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // input tdata layout, lowest bit up
    localparam int IDX_LSB = 0;
    localparam int KEYW_LSB = IDX_LSB + KEY_IDX_W;
    localparam int CTR_LSB = KEYW_LSB + WORD_W;
    localparam int DLO_LSB = CTR_LSB + WORD_W;
    localparam int DHI_LSB = DLO_LSB + HALF_W;
    localparam int CNT_LSB = DHI_LSB + HALF_W;

    typedef struct {
        logic [KIND_W-1:0]    kind;
        logic [KEY_IDX_W-1:0] key_index;
        logic [WORD_W-1:0]    key_word;
        logic [WORD_W-1:0]    counter_start;
        logic [HALF_W-1:0]    data_low;
        logic [HALF_W-1:0]    data_high;
        logic [COUNT_W-1:0]   byte_count;
    } t_cipher_beat;

    typedef struct {
        logic [HALF_W-1:0]  text_low;
        logic [HALF_W-1:0]  text_high;
        logic [COUNT_W-1:0] bytes;
        logic [WORD_W-1:0]  counter;
    } t_cipher_block;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [WORD_W-1:0]      i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // key_index, key_word, counter_start, data_low, data_high, byte_count
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    // kind
    logic [KIND_W-1:0]      s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // result_low, result_high, result_bytes, counter_used
    logic [M_TDATA_W-1:0]   m_axis_tdata;

    // predictor state
    logic [WORD_W-1:0] nonce_model [3];
    logic [WORD_W-1:0] key_model [KEY_DEPTH];
    logic [WORD_W-1:0] counter_model;
    t_cipher_block     pending_blocks [$];

    int  errors = 0;
    int  beats_sent = 0;
    bit  steady = 1'b0;
    int  rx_stall_left = 0;

    arx_mul_ctr_keystream_cipher #(.ROUNDS(ROUND_COUNT)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [WORD_W-1:0] rotate_left(input logic [WORD_W-1:0] x, input int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic logic [HALF_W-1:0] low_bytes_mask(input int n);
        logic [HALF_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < n) m[8*i +: 8] = 8'hff;
        end
        return m;
    endfunction

    // 16 keystream bytes for one counter value, word 0 in the low bits
    function automatic logic [BLOCK_W-1:0] keystream_block(input logic [WORD_W-1:0] ctr);
        logic [WORD_W-1:0] v0, v1, v2, v3, u, p;
        int base;
        v0 = nonce_model[0];
        v1 = nonce_model[1];
        v2 = nonce_model[2];
        v3 = ctr;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            base = (4 * r) % KEY_DEPTH;
            u  = v2 + v3;
            v0 = rotate_left(v0, 13) + v1 + u;
            v1 = rotate_left(v1, 7) + u + v0;
            p  = v0 + v1;
            v2 = rotate_left(v2, 11) + v3 + p;
            v3 = rotate_left(v3, 15) + p + v2;
            v0 = (v0 * 32'h71e961dd) ^ key_model[base];
            v1 = (v1 * 32'h47dff15d) ^ key_model[(base + 1) % KEY_DEPTH];
            v2 = (v2 * 32'h172f4f2f) ^ key_model[(base + 2) % KEY_DEPTH];
            v3 = (v3 * 32'hf9c1e3c7) ^ key_model[(base + 3) % KEY_DEPTH];
        end
        return {v3, v2, v1, v0};
    endfunction

    // update the predictor for one accepted beat
    function automatic void apply_beat(input t_cipher_beat b);
        logic [BLOCK_W-1:0] ks;
        t_cipher_block blk;
        int cnt;
        case (b.kind)
            KIND_KEY:   key_model[b.key_index] = b.key_word;
            KIND_START: counter_model = b.counter_start;
            KIND_DATA: begin
                cnt = (b.byte_count > 16) ? 16 : int'(b.byte_count);
                if (cnt != 0) begin
                    ks = keystream_block(counter_model);
                    blk.text_low  = (b.data_low ^ ks[63:0]) & low_bytes_mask(cnt);
                    blk.text_high = (cnt > 8) ?
                                    ((b.data_high ^ ks[127:64]) & low_bytes_mask(cnt - 8)) : '0;
                    blk.bytes     = COUNT_W'(cnt);
                    blk.counter   = counter_model;
                    pending_blocks.push_back(blk);
                    counter_model = counter_model + 1;
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        t_cipher_block want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_blocks.size() == 0) begin
                $display("%0t: unexpected output block %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_blocks.pop_front();
                if (m_axis_tdata[63:0] !== want.text_low) begin
                    $display("%0t: result_low expected %h actual %h",
                             $time, want.text_low, m_axis_tdata[63:0]);
                    errors++;
                end
                if (m_axis_tdata[127:64] !== want.text_high) begin
                    $display("%0t: result_high expected %h actual %h",
                             $time, want.text_high, m_axis_tdata[127:64]);
                    errors++;
                end
                if (m_axis_tdata[132:128] !== want.bytes) begin
                    $display("%0t: result_bytes expected %0d actual %0d",
                             $time, want.bytes, m_axis_tdata[132:128]);
                    errors++;
                end
                if (m_axis_tdata[164:133] !== want.counter) begin
                    $display("%0t: counter_used expected %h actual %h",
                             $time, want.counter, m_axis_tdata[164:133]);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure: short random stalls, rarely a long one
    always @(negedge i_clk) begin
        if (steady) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3999) == 0) begin
            rx_stall_left = $urandom_range(60, 140);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 17);
        end
    end

    // ---------------- beat helpers ----------------

    // all fields random so unused ones toggle too
    function automatic t_cipher_beat noise_beat(input logic [KIND_W-1:0] kind);
        t_cipher_beat b;
        b.kind          = kind;
        b.key_index     = KEY_IDX_W'($urandom);
        b.key_word      = $urandom;
        b.counter_start = $urandom;
        b.data_low      = {$urandom, $urandom};
        b.data_high     = {$urandom, $urandom};
        b.byte_count    = COUNT_W'($urandom_range(0, 31));
        return b;
    endfunction

    function automatic t_cipher_beat key_beat(input int idx, input logic [WORD_W-1:0] w);
        t_cipher_beat b;
        b = noise_beat(KIND_KEY);
        b.key_index = KEY_IDX_W'(idx);
        b.key_word  = w;
        return b;
    endfunction

    function automatic t_cipher_beat start_beat(input logic [WORD_W-1:0] ctr);
        t_cipher_beat b;
        b = noise_beat(KIND_START);
        b.counter_start = ctr;
        return b;
    endfunction

    function automatic t_cipher_beat data_beat(input logic [HALF_W-1:0] lo,
                                               input logic [HALF_W-1:0] hi, input int cnt);
        t_cipher_beat b;
        b = noise_beat(KIND_DATA);
        b.data_low   = lo;
        b.data_high  = hi;
        b.byte_count = COUNT_W'(cnt);
        return b;
    endfunction

    function automatic t_cipher_beat random_data_beat(input int cnt);
        return data_beat({$urandom, $urandom}, {$urandom, $urandom}, cnt);
    endfunction

    // drive one beat from a falling edge, return at the falling edge after acceptance
    task automatic send_beat(input t_cipher_beat b);
        logic [S_TDATA_W-1:0] t;
        int gap;
        if (!steady) begin
            gap = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 60) : 0;
            while (gap > 0 || $urandom_range(0, 99) < 17) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
                if (gap > 0) gap--;
            end
        end
        t = '0;
        t[IDX_LSB +: KEY_IDX_W] = b.key_index;
        t[KEYW_LSB +: WORD_W]   = b.key_word;
        t[CTR_LSB +: WORD_W]    = b.counter_start;
        t[DLO_LSB +: HALF_W]    = b.data_low;
        t[DHI_LSB +: HALF_W]    = b.data_high;
        t[CNT_LSB +: COUNT_W]   = b.byte_count;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        s_axis_tuser  <= b.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        apply_beat(b);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // stop sending, wait for every block, then let the core drain
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_blocks.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_nonces(input logic [WORD_W-1:0] n0, input logic [WORD_W-1:0] n1,
                              input logic [WORD_W-1:0] n2);
        logic [WORD_W-1:0] vals [3];
        vals = '{n0, n1, n2};
        drain();
        for (int i = 0; i < 3; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= (i == 0) ? CFG_NONCE0 : (i == 1) ? CFG_NONCE1 : CFG_NONCE2;
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            nonce_model[i] = vals[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // ---------------- tests ----------------

    // fill the whole key store, extremes at both ends
    task automatic test_key_load;
        for (int i = 0; i < KEY_DEPTH; i++) begin
            send_beat(key_beat(i, (i == 0) ? 32'h0 :
                               (i == KEY_DEPTH - 1) ? 32'hffffffff : $urandom));
        end
    endtask

    // full and short blocks, data extremes
    task automatic test_byte_counts;
        send_beat(start_beat(32'h0));
        send_beat(data_beat('0, '0, 16));
        send_beat(data_beat('1, '1, 16));
        send_beat(random_data_beat(1));
        send_beat(random_data_beat(8));
        send_beat(random_data_beat(9));
        send_beat(random_data_beat(15));
    endtask

    // zero count dropped, oversized counts saturate, unused kind ignored
    task automatic test_odd_beats;
        send_beat(random_data_beat(0));
        send_beat(random_data_beat(17));
        send_beat(noise_beat(KIND_UNUSED));
        send_beat(random_data_beat(31));
    endtask

    // block counter wraps past all ones
    task automatic test_counter_wrap;
        send_beat(start_beat(32'hffffffff));
        send_beat(random_data_beat(16));
        send_beat(random_data_beat(5));
    endtask

    task automatic test_nonce_extremes;
        set_nonces(32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_beat(start_beat(32'h0));
        send_beat(data_beat('1, '0, 16));
        set_nonces(32'h0, 32'hffffffff, 32'h80000001);
        send_beat(start_beat(32'h7fffffff));
        send_beat(random_data_beat(12));
    endtask

    // messages with random content, plus key updates and malformed beats
    task automatic test_random;
        int target;
        int pick;
        int blocks;
        target = beats_sent + 330;
        for (int phase = 0; phase < 6; phase++) begin
            set_nonces($urandom, $urandom, $urandom);
            steady = (phase == 2);
            while (beats_sent < target * (phase + 1) / 6 + (target - 330) * (5 - phase) / 6) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_beat(start_beat(($urandom_range(0, 3) == 0) ?
                                         32'hffffffff - $urandom_range(0, 3) : $urandom));
                    blocks = $urandom_range(1, 6);
                    for (int k = 1; k < blocks; k++) send_beat(random_data_beat(16));
                    send_beat(random_data_beat($urandom_range(1, 16)));
                end else if (pick < 80) begin
                    send_beat(key_beat($urandom_range(0, KEY_DEPTH - 1), $urandom));
                end else if (pick < 86) begin
                    send_beat(noise_beat(KIND_UNUSED));
                end else if (pick < 92) begin
                    send_beat(random_data_beat(($urandom_range(0, 1) == 0) ?
                                               0 : $urandom_range(17, 31)));
                end else begin
                    send_beat(random_data_beat($urandom_range(1, 31)));
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_NONCE0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_KEY;
        nonce_model   = '{32'h0, 32'h0, 32'h0};
        counter_model = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_key_load();
        test_byte_counts();
        test_odd_beats();
        test_counter_wrap();
        test_nonce_extremes();
        test_random();

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
